>>> src/chord_strum_spreader_unit_macros.svh
// Assertion macros for the chord strum spreader RTL.
// Included by chord_strum_spreader_unit, which carries concurrent checks; depends on nothing.
`ifndef CHORD_STRUM_SPREADER_UNIT_MACROS_SVH
`define CHORD_STRUM_SPREADER_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define CSS_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
`define CSS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CSS_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg)
`define CSS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

>>> src/css_pkg.sv
// Shared types and constants of the chord strum spreader.
// Used by css_cell and chord_strum_spreader_unit; depends on nothing.
`timescale 1ns / 1ps
package css_pkg;

    localparam int TIME_W    = 32;
    localparam int PITCH_W   = 7;
    localparam int PAYLOAD_W = 32;
    // Smallest group that gets sorted and strummed.
    localparam int MIN_CHORD = 3;

    typedef logic signed [TIME_W-1:0] start_t;
    typedef logic [PITCH_W-1:0]       pitch_t;
    typedef logic [PAYLOAD_W-1:0]     payload_t;

    typedef struct packed {
        start_t   note_start;
        pitch_t   note_pitch;
        payload_t note_payload;
        logic     end_of_list;
    } note_in_t;

    typedef struct packed {
        start_t   out_start;
        pitch_t   out_pitch;
        payload_t out_payload;
        logic     out_last;
    } note_out_t;

    typedef struct packed {
        logic shift;
        logic sort_en;
        logic sort_odd;
    } cell_ctl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_PLACE,
        ST_SORT,
        ST_DRAIN,
        ST_NOTE
    } css_state_t;

    typedef enum logic [1:0] {
        PH_FIRST,
        PH_OVER,
        PH_EOL
    } css_phase_t;

endpackage

>>> src/css_cell.sv
// One slot of the group buffer: holds a pitch and a payload, loads a new note,
// shifts toward slot zero and takes part in odd-even transposition sorting.
// Depends on css_pkg.
`timescale 1ns / 1ps
module css_cell #(
    parameter int IDX = 0,
    parameter int CW  = 3
) (
    input  logic              aclk,
    input  css_pkg::cell_ctl_t ctl,
    input  logic              load,
    input  logic [CW-1:0]     count,
    input  css_pkg::pitch_t   load_pitch,
    input  css_pkg::payload_t load_payload,
    input  css_pkg::pitch_t   left_pitch,
    input  css_pkg::pitch_t   right_pitch,
    input  css_pkg::payload_t right_payload,
    output css_pkg::pitch_t   pitch,
    output css_pkg::payload_t payload
);
    import css_pkg::*;

    localparam logic [CW:0] POS      = (CW + 1)'(IDX);
    localparam logic [CW:0] POS_NEXT = (CW + 1)'(IDX + 1);
    localparam logic        LO_PAR   = 1'(IDX % 2);
    localparam logic        UP_PAR   = 1'((IDX + 1) % 2);

    pitch_t   pitch_reg, pitch_next;
    payload_t payload_reg, payload_next;
    logic     is_lower, is_upper;

    // In each sort phase a cell is either the low or the high member of a
    // pair, and only when both members hold notes of the group.
    always_comb begin
        is_lower = ctl.sort_en && (ctl.sort_odd == LO_PAR) && (POS_NEXT < {1'b0, count});
        is_upper = ctl.sort_en && (IDX > 0) && (ctl.sort_odd == UP_PAR)
                   && (POS < {1'b0, count});
        pitch_next   = pitch_reg;
        payload_next = payload_reg;
        if (load) begin
            pitch_next   = load_pitch;
            payload_next = load_payload;
        end else if (ctl.shift) begin
            pitch_next   = right_pitch;
            payload_next = right_payload;
        end else if (is_lower && (pitch_reg > right_pitch)) begin
            pitch_next = right_pitch;
        end else if (is_upper && (left_pitch > pitch_reg)) begin
            pitch_next = left_pitch;
        end
    end

    always_ff @(posedge aclk) begin
        pitch_reg   <= pitch_next;
        payload_reg <= payload_next;
    end

    assign pitch   = pitch_reg;
    assign payload = payload_reg;

endmodule

>>> src/chord_strum_spreader_unit.sv
// Channel  Dir  Payload     Handshake
// s_       in   note_in_t   s_valid / s_ready
// m_       out  note_out_t  m_valid / m_ready
//
// A note that only joins the buffer passes two steps: accept, then decide.
// Flushing a group of n notes first sorts it when n is 3 or more, then drains
// it at one word per cycle out of slot zero of the cell row.
// Input is taken only when the controller is idle; a stalled m_ready holds
// the drain. Reset (aresetn low, synchronous) empties the group.
`timescale 1ns / 1ps
`include "chord_strum_spreader_unit_macros.svh"
module chord_strum_spreader_unit #(
    parameter int MAX_GROUP = 6
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  css_pkg::note_in_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output css_pkg::note_out_t m_data
);
    import css_pkg::*;

    localparam int            CW        = $clog2(MAX_GROUP + 1);
    localparam logic [CW-1:0] CNT_MAX   = CW'(MAX_GROUP);
    localparam logic [CW-1:0] CNT_CHORD = CW'(MIN_CHORD);

    css_state_t    state_reg, state_next;
    css_phase_t    phase_reg, phase_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] sort_cnt_reg, sort_cnt_next;
    logic          xform_reg, xform_next;
    logic          osz_reg, osz_next;
    start_t        gstart_reg, gstart_next;
    note_in_t      hold_reg, hold_next;
    logic          m_valid_reg, m_valid_next;
    note_out_t     m_data_reg, m_data_next;

    cell_ctl_t     ctl;
    logic          load_en;
    logic          place;
    logic          flush_start;
    logic [CW-1:0] flush_n;
    logic          out_free;
    logic          same_start;
    logic [TIME_W-1:0] strum;

    pitch_t   cell_pitch   [MAX_GROUP];
    payload_t cell_payload [MAX_GROUP];

    for (genvar i = 0; i < MAX_GROUP; i++) begin : g_cell
        localparam int L = (i > 0) ? i - 1 : i;
        localparam int R = (i < MAX_GROUP - 1) ? i + 1 : i;
        css_cell #(
            .IDX(i),
            .CW (CW)
        ) u_cell (
            .aclk         (aclk),
            .ctl          (ctl),
            .load         (load_en && (count_reg == CW'(i))),
            .count        (count_reg),
            .load_pitch   (hold_reg.note_pitch),
            .load_payload (hold_reg.note_payload),
            .left_pitch   (cell_pitch[L]),
            .right_pitch  (cell_pitch[R]),
            .right_payload(cell_payload[R]),
            .pitch        (cell_pitch[i]),
            .payload      (cell_payload[i])
        );
    end

    assign s_ready    = (state_reg == ST_IDLE);
    assign m_valid    = m_valid_reg;
    assign m_data     = m_data_reg;
    assign out_free   = !m_valid_reg || m_ready;
    assign same_start = (hold_reg.note_start == gstart_reg);
    assign strum      = xform_reg ? TIME_W'(idx_reg >> 1) : '0;

    always_comb begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        sort_cnt_next = sort_cnt_reg;
        xform_next    = xform_reg;
        osz_next      = osz_reg;
        gstart_next   = gstart_reg;
        hold_next     = hold_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;
        ctl           = '0;
        load_en       = 1'b0;
        place         = 1'b0;
        flush_start   = 1'b0;
        flush_n       = count_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    hold_next  = s_data;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (osz_reg && same_start) begin
                    // Over-long group still streaming: the note goes out as is.
                    if (out_free) begin
                        m_valid_next = 1'b1;
                        m_data_next  = '{hold_reg.note_start, hold_reg.note_pitch,
                                         hold_reg.note_payload, 1'b1};
                        osz_next     = !hold_reg.end_of_list;
                        state_next   = ST_IDLE;
                    end
                end else begin
                    osz_next = 1'b0;
                    if ((count_reg != '0) && !same_start) begin
                        flush_start = 1'b1;
                        phase_next  = PH_FIRST;
                    end else begin
                        place = 1'b1;
                    end
                end
            end
            ST_PLACE: begin
                place = 1'b1;
            end
            ST_SORT: begin
                ctl.sort_en   = 1'b1;
                ctl.sort_odd  = sort_cnt_reg[0];
                sort_cnt_next = sort_cnt_reg + 1'b1;
                if (sort_cnt_reg == count_reg - 1'b1) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '{start_t'($unsigned(gstart_reg) + strum),
                                     cell_pitch[0], cell_payload[0],
                                     (count_reg == CW'(1))
                                     && ((phase_reg == PH_EOL)
                                         || ((phase_reg == PH_FIRST)
                                             && !hold_reg.end_of_list))};
                    ctl.shift    = 1'b1;
                    count_next   = count_reg - 1'b1;
                    idx_next     = idx_reg + 1'b1;
                    if (count_reg == CW'(1)) begin
                        case (phase_reg)
                            PH_FIRST: state_next = ST_PLACE;
                            PH_OVER:  state_next = ST_NOTE;
                            default:  state_next = ST_IDLE;
                        endcase
                    end
                end
            end
            ST_NOTE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '{hold_reg.note_start, hold_reg.note_pitch,
                                     hold_reg.note_payload, 1'b1};
                    osz_next     = !hold_reg.end_of_list;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (place) begin
            if (count_reg == '0) begin
                load_en     = 1'b1;
                gstart_next = hold_reg.note_start;
                count_next  = CW'(1);
                if (hold_reg.end_of_list) begin
                    flush_start = 1'b1;
                    flush_n     = CW'(1);
                    phase_next  = PH_EOL;
                end else begin
                    state_next = ST_IDLE;
                end
            end else if (count_reg < CNT_MAX) begin
                load_en    = 1'b1;
                count_next = count_reg + 1'b1;
                if (hold_reg.end_of_list) begin
                    flush_start = 1'b1;
                    flush_n     = count_reg + 1'b1;
                    phase_next  = PH_EOL;
                end else begin
                    state_next = ST_IDLE;
                end
            end else begin
                // Group is full and one more note arrived: dump it unsorted.
                state_next = ST_DRAIN;
                phase_next = PH_OVER;
                xform_next = 1'b0;
                idx_next   = '0;
            end
        end

        if (flush_start) begin
            xform_next    = (flush_n >= CNT_CHORD);
            idx_next      = '0;
            sort_cnt_next = '0;
            state_next    = (flush_n >= CNT_CHORD) ? ST_SORT : ST_DRAIN;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            phase_reg   <= PH_FIRST;
            count_reg   <= '0;
            osz_reg     <= 1'b0;
            gstart_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            count_reg   <= count_next;
            osz_reg     <= osz_next;
            gstart_reg  <= gstart_next;
            m_valid_reg <= m_valid_next;
        end
        idx_reg      <= idx_next;
        sort_cnt_reg <= sort_cnt_next;
        xform_reg    <= xform_next;
        hold_reg     <= hold_next;
        m_data_reg   <= m_data_next;
    end

    // While an over-long group streams through, nothing is buffered.
    `CSS_ASSERT_IMPLY(a_osz_empty, aclk, aresetn, osz_reg, count_reg == '0, "buffer not empty in passthrough")
    `CSS_ASSERT_IMPLY(a_count_max, aclk, aresetn, 1'b1, count_reg <= CNT_MAX, "group count overflow")
    `CSS_ASSERT_IMPLY(a_sort_size, aclk, aresetn, state_reg == ST_SORT, count_reg >= CNT_CHORD, "sorting a short group")
    `CSS_ASSERT_NEXT(a_accept_decide, aclk, aresetn, s_valid && s_ready, state_reg == ST_DECIDE, "accepted word not decoded")

endmodule
